### rtl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared types and codes for the indexed list insert/delete block.
// ----------------------------------------------------------------------------
package ilid_pkg;

   localparam int ValueWidth = 32;
   localparam int PosWidth   = 5;
   localparam int CountWidth = 5;

   localparam logic OpInsert = 1'b0;
   localparam logic OpDelete = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic signed [ValueWidth-1:0]  value;
   } cell_ctrl_type;

   localparam logic signed [ValueWidth-1:0] NoneRemoved = '1;

endpackage

### rtl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of signed 32-bit entries with indexed insert and delete,
// held in a row of cells that shift together.
// ----------------------------------------------------------------------------
// One transfer in, one result out: an insert puts value at 0-based position
// and moves later entries up; a delete removes 1-based entry position and
// returns it. The whole cell row shifts in the cycle an item is accepted,
// and the result lands in an output register, so a new item is accepted
// every cycle while that register is empty or being drained. Entries above
// the count are never returned.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_op,
   input  logic [ilid_pkg::PosWidth-1:0]            req_position,
   input  logic signed [ilid_pkg::ValueWidth-1:0]   req_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic signed [ilid_pkg::ValueWidth-1:0]   rsp_removed_value,
   output logic [ilid_pkg::CountWidth-1:0]          rsp_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > ilid_pkg::PosWidth) ? CW : ilid_pkg::PosWidth;
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [CW-1:0]                             fill_ff;
   logic [CW-1:0]                             fill_in;
   logic                                      rsp_valid_ff;
   logic                                      rsp_valid_in;
   ilid_pkg::status_type                      rsp_status_ff;
   ilid_pkg::status_type                      status_in;
   logic signed [ilid_pkg::ValueWidth-1:0]    rsp_removed_ff;
   logic signed [ilid_pkg::ValueWidth-1:0]    removed_in;
   logic [ilid_pkg::CountWidth-1:0]           rsp_count_ff;

   logic                                      req_fire;
   logic [XW-1:0]                             pos_x;
   logic [XW-1:0]                             fill_x;
   logic [XW-1:0]                             slot_x;
   logic [XW-1:0]                             cell_pos;
   ilid_pkg::cell_ctrl_type                   ctrl;
   logic signed [ilid_pkg::ValueWidth-1:0]    cell_data [CAPACITY];

   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign pos_x     = XW'(req_position);
   assign fill_x    = XW'(fill_ff);
   assign slot_x    = pos_x - XW'(1);

   always_comb begin
      status_in  = ilid_pkg::ST_OK;
      removed_in = ilid_pkg::NoneRemoved;
      fill_in    = fill_ff;
      ctrl.cmd   = ilid_pkg::CMD_HOLD;
      ctrl.value = req_value;
      cell_pos   = pos_x;
      if (req_op == ilid_pkg::OpInsert) begin
         if (pos_x > fill_x) begin
            status_in = ilid_pkg::ST_RANGE;
         end else if (fill_ff == CW'(CAPACITY)) begin
            status_in = ilid_pkg::ST_FULL;
         end else begin
            fill_in  = fill_ff + CW'(1);
            ctrl.cmd = req_fire ? ilid_pkg::CMD_INSERT : ilid_pkg::CMD_HOLD;
         end
      end else begin
         cell_pos = slot_x;
         if (pos_x == '0 || pos_x > fill_x) begin
            status_in = ilid_pkg::ST_RANGE;
         end else begin
            removed_in = cell_data[slot_x[IW-1:0]];
            fill_in    = fill_ff - CW'(1);
            ctrl.cmd   = req_fire ? ilid_pkg::CMD_DELETE : ilid_pkg::CMD_HOLD;
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ilid_pkg::ValueWidth-1:0] left_data;
      logic signed [ilid_pkg::ValueWidth-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = cell_data[i];
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      ilid_cell #(
         .INDEX (i),
         .XW    (XW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (cell_pos),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff  <= status_in;
         rsp_removed_ff <= removed_in;
         rsp_count_ff   <= ilid_pkg::CountWidth'(fill_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && status_in != ilid_pkg::ST_OK) |=> $stable(fill_ff))
      else $error("rejected item changed fill count");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == ilid_pkg::OpInsert && status_in == ilid_pkg::ST_OK)
         |=> fill_ff == $past(fill_ff) + CW'(1))
      else $error("insert did not grow list");

   a_no_removed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ilid_pkg::ST_OK)
         |-> rsp_removed_ff == ilid_pkg::NoneRemoved)
      else $error("rejected item reports a removed value");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $past(req_fire) |-> rsp_count_ff == ilid_pkg::CountWidth'(fill_ff))
      else $error("result count differs from fill count");

endmodule

### rtl/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// One slot of the list: holds an entry, loads the new value, takes its
// left neighbor on an insert below it, or its right neighbor on a delete at or below it.
// ----------------------------------------------------------------------------
module ilid_cell #(
   parameter int INDEX = 0,
   parameter int XW    = 5
) (
   input  logic                                     clock,
   input  ilid_pkg::cell_ctrl_type                  ctrl,
   input  logic [XW-1:0]                            pos,
   input  logic signed [ilid_pkg::ValueWidth-1:0]   left_data,
   input  logic signed [ilid_pkg::ValueWidth-1:0]   right_data,
   output logic signed [ilid_pkg::ValueWidth-1:0]   data
);

   localparam logic [XW-1:0] MyIndex = XW'(INDEX);

   logic signed [ilid_pkg::ValueWidth-1:0] data_ff;
   logic signed [ilid_pkg::ValueWidth-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         ilid_pkg::CMD_INSERT: begin
            if (MyIndex > pos) begin
               data_in = left_data;
            end else if (MyIndex == pos) begin
               data_in = ctrl.value;
            end
         end
         ilid_pkg::CMD_DELETE: begin
            if (MyIndex >= pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
